// ----- hw/rtl/gbm_pkg.sv -----
// Shared types, constants and control records for the greedy box merge block.
`timescale 1ns / 1ps

package gbm_pkg;

  // Field widths of the box items and of the merge limit register.
  localparam int COORD_W       = 10;
  localparam int AREA_W        = 2 * COORD_W;
  localparam int DIST_W        = 2 * COORD_W + 1;
  localparam int LIMIT_W       = 22;
  localparam int MAX_BOXES_DEF = 64;

  // Configuration port layout: one 22-bit register at byte address zero of the 32-bit data port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_LIMIT_IDX = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5184);

  // An input item: the left, top, right and bottom edges of a box and the frame markers.
  typedef struct packed {
    logic [COORD_W-1:0] left_edge;
    logic [COORD_W-1:0] top_edge;
    logic [COORD_W-1:0] right_edge;
    logic [COORD_W-1:0] bottom_edge;
    logic               box_present;
    logic               last_box;
  } in_item_t;

  // One result item: a merged box with its valid and last markers.
  typedef struct packed {
    logic [COORD_W-1:0] out_left;
    logic [COORD_W-1:0] out_top;
    logic [COORD_W-1:0] out_right;
    logic [COORD_W-1:0] out_bottom;
    logic               out_valid;
    logic               out_last;
  } out_item_t;

  // A stored box and one word of the box memory.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    box_t              box;
    logic [AREA_W-1:0] area;
  } entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_START,
    ST_FIND,
    ST_SEED,
    ST_MERGE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic scan_start;
    logic scan_merge;
    logic out_load;
    logic out_last;
    logic out_empty;
    logic clear_count;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_busy;
    logic seed_found;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/gbm_ctrl.sv -----
// Controller state machine that sequences box storage, seed search and merge passes.
`timescale 1ns / 1ps

module gbm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_present,
  input  logic               in_last,
  output logic               in_ready,
  input  gbm_pkg::dp_stat_t  stat,
  output gbm_pkg::ctrl_cmd_t cmd
);

  gbm_pkg::state_t state;
  gbm_pkg::state_t state_next;
  logic            pend;
  logic            pend_next;

  // State register and the flag that a merged box waits to be sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbm_pkg::ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      gbm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = in_present;
          if (in_last) begin
            state_next = gbm_pkg::ST_FIND_START;
          end
        end
      end
      gbm_pkg::ST_FIND_START: begin
        cmd.scan_start = 1'b1;
        state_next     = gbm_pkg::ST_FIND;
      end
      gbm_pkg::ST_FIND: begin
        if (!stat.scan_busy) begin
          state_next = stat.seed_found ? gbm_pkg::ST_SEED : gbm_pkg::ST_FINISH;
        end
      end
      gbm_pkg::ST_SEED: begin
        // The previous union goes out, not marked last, before the next one starts.
        if (!pend || stat.out_free) begin
          cmd.out_load   = pend;
          cmd.scan_start = 1'b1;
          cmd.scan_merge = 1'b1;
          pend_next      = 1'b1;
          state_next     = gbm_pkg::ST_MERGE;
        end
      end
      gbm_pkg::ST_MERGE: begin
        if (!stat.scan_busy) begin
          state_next = gbm_pkg::ST_FIND_START;
        end
      end
      gbm_pkg::ST_FINISH: begin
        // The frame's closing item: the held union, or an empty marker.
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_last    = 1'b1;
          cmd.out_empty   = !pend;
          cmd.clear_count = 1'b1;
          pend_next       = 1'b0;
          state_next      = gbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gbm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/gbm_dpath.sv -----
// Datapath with the box memory, the scan pipeline, the union register and the result register.
`timescale 1ns / 1ps

module gbm_dpath #(
  parameter int MAX_BOXES = gbm_pkg::MAX_BOXES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gbm_pkg::ctrl_cmd_t            cmd,
  output gbm_pkg::dp_stat_t             stat,
  input  gbm_pkg::in_item_t             in_item,
  input  logic [gbm_pkg::LIMIT_W-1:0]   limit,
  output logic                          res_valid,
  input  logic                          res_ready,
  output gbm_pkg::out_item_t            res_item
);

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int CW    = gbm_pkg::COORD_W;
  localparam int AW    = gbm_pkg::AREA_W;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CW-1:0] center(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum    = {1'b0, a} + {1'b0, b};
    center = sum[CW:1];
  endfunction

  // Box memory and consumed flags; only entries below the count are used by a scan.
  gbm_pkg::entry_t mem [MAX_BOXES];
  logic            flag_mem [MAX_BOXES];

  logic [CNT_W-1:0]  count;
  logic              full;
  logic              wr_store;
  gbm_pkg::box_t     in_box;
  logic [AW-1:0]     in_area;

  logic              issuing;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  rd_idx_inc;
  logic              scan_merge;
  gbm_pkg::entry_t   rd_entry;
  logic              rd_flag;
  logic              p1_vld;
  logic [IDX_W-1:0]  p1_idx;

  logic              found;
  logic [AW-1:0]     best_area;
  gbm_pkg::box_t     best_box;
  logic [IDX_W-1:0]  seed_idx;
  logic [CW-1:0]     seed_cx;
  logic [CW-1:0]     seed_cy;

  logic [CW-1:0]     p1_dx;
  logic [CW-1:0]     p1_dy;
  logic              p2_vld;
  logic [IDX_W-1:0]  p2_idx;
  gbm_pkg::box_t     p2_box;
  logic [AW-1:0]     sq_x;
  logic [AW-1:0]     sq_y;
  logic [gbm_pkg::DIST_W-1:0] dist_sq;
  logic              hit;
  gbm_pkg::box_t     uni;

  // Incoming box and its area.
  assign in_box.left   = in_item.left_edge;
  assign in_box.top    = in_item.top_edge;
  assign in_box.right  = in_item.right_edge;
  assign in_box.bottom = in_item.bottom_edge;
  assign in_area  = AW'(abs_diff(in_item.bottom_edge, in_item.top_edge)) *
                    AW'(abs_diff(in_item.right_edge, in_item.left_edge));
  assign full     = (count == CNT_W'(MAX_BOXES));
  assign wr_store = cmd.store && !full;

  // Box memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_store) begin
      mem[count[IDX_W-1:0]] <= '{box: in_box, area: in_area};
    end
    rd_entry <= mem[rd_idx[IDX_W-1:0]];
  end

  // Consumed flags: cleared as a box is stored, set when it joins a union.
  always_ff @(posedge clk) begin
    if (wr_store) begin
      flag_mem[count[IDX_W-1:0]] <= 1'b0;
    end else if (hit) begin
      flag_mem[p2_idx] <= 1'b1;
    end
    rd_flag <= flag_mem[rd_idx[IDX_W-1:0]];
  end

  // Box count of the current frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (wr_store) begin
      count <= count + CNT_W'(1);
    end
  end

  // Read address sequencer and pipeline valid bits.
  assign rd_idx_inc = rd_idx + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      rd_idx     <= '0;
      scan_merge <= 1'b0;
      p1_vld     <= 1'b0;
      p2_vld     <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        issuing    <= (count != '0);
        rd_idx     <= '0;
        scan_merge <= cmd.scan_merge;
      end else if (issuing) begin
        issuing <= (rd_idx_inc != count);
        rd_idx  <= rd_idx_inc;
      end
      p1_vld <= issuing;
      p2_vld <= p1_vld && scan_merge && !rd_flag;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= rd_idx[IDX_W-1:0];
  end

  // Seed search: largest area among unconsumed boxes, first one on ties.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.scan_start && !cmd.scan_merge) begin
      found <= 1'b0;
    end else if (p1_vld && !scan_merge && !rd_flag &&
                 (!found || rd_entry.area > best_area)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start && !cmd.scan_merge) begin
      best_area <= '0;
    end else if (p1_vld && !scan_merge && !rd_flag &&
                 (!found || rd_entry.area > best_area)) begin
      best_area <= rd_entry.area;
      best_box  <= rd_entry.box;
      seed_idx  <= p1_idx;
    end
  end

  // Seed center, taken from the seed's original edges.
  always_ff @(posedge clk) begin
    if (cmd.scan_start && cmd.scan_merge) begin
      seed_cx <= center(best_box.left, best_box.right);
      seed_cy <= center(best_box.top, best_box.bottom);
    end
  end

  // Merge stage one: center offsets squared.
  assign p1_dx = abs_diff(seed_cx, center(rd_entry.box.left, rd_entry.box.right));
  assign p1_dy = abs_diff(seed_cy, center(rd_entry.box.top, rd_entry.box.bottom));

  always_ff @(posedge clk) begin
    sq_x   <= AW'(p1_dx) * AW'(p1_dx);
    sq_y   <= AW'(p1_dy) * AW'(p1_dy);
    p2_box <= rd_entry.box;
    p2_idx <= p1_idx;
  end

  // Merge stage two: distance test; the seed always joins its own union.
  assign dist_sq = gbm_pkg::DIST_W'(sq_x) + gbm_pkg::DIST_W'(sq_y);
  assign hit     = p2_vld && ((gbm_pkg::LIMIT_W'(dist_sq) < limit) || (p2_idx == seed_idx));

  always_ff @(posedge clk) begin
    if (cmd.scan_start && cmd.scan_merge) begin
      uni <= best_box;
    end else if (hit) begin
      if (p2_box.left < uni.left) begin
        uni.left <= p2_box.left;
      end
      if (p2_box.top < uni.top) begin
        uni.top <= p2_box.top;
      end
      if (p2_box.right > uni.right) begin
        uni.right <= p2_box.right;
      end
      if (p2_box.bottom > uni.bottom) begin
        uni.bottom <= p2_box.bottom;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        res_item.out_left   <= '0;
        res_item.out_top    <= '0;
        res_item.out_right  <= '0;
        res_item.out_bottom <= '0;
        res_item.out_valid  <= 1'b0;
      end else begin
        res_item.out_left   <= uni.left;
        res_item.out_top    <= uni.top;
        res_item.out_right  <= uni.right;
        res_item.out_bottom <= uni.bottom;
        res_item.out_valid  <= 1'b1;
      end
      res_item.out_last <= cmd.out_last;
    end
  end

  // Status back to the controller.
  assign stat.scan_busy  = issuing || p1_vld || p2_vld;
  assign stat.seed_found = found && (best_area != '0);
  assign stat.out_free   = !res_valid || res_ready;

endmodule

// ----- hw/rtl/greedy_box_merge_top.sv -----
// Top level of the greedy box merge block: configuration register and unit wiring.
`timescale 1ns / 1ps

// Boxes of a frame arrive one item per cycle and are written to a box memory of
// MAX_BOXES entries together with their areas; boxes past a full memory are dropped.
// The item that carries last_box closes the frame and input stays stalled while the
// merge runs. Each merged box costs one search pass and one merge pass over the N
// stored boxes through the memory's single read port; a final search pass that finds
// no seed closes the frame, and only then is the next frame taken. A result waiting
// in the output register stalls the merge only when the next result is ready. The
// merge limit register sits at byte address 0 of the configuration port and resets
// to 5184.
module greedy_box_merge_top #(
  parameter int MAX_BOXES = gbm_pkg::MAX_BOXES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  gbm_pkg::in_item_t                in_item,
  output logic                             res_valid,
  input  logic                             res_ready,
  output gbm_pkg::out_item_t               res_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gbm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gbm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gbm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [gbm_pkg::LIMIT_W-1:0] limit;
  logic                        reg_sel;
  gbm_pkg::ctrl_cmd_t          cmd;
  gbm_pkg::dp_stat_t           stat;

  // Merge limit register.
  assign reg_sel = (paddr[gbm_pkg::APB_ADDR_W-1] == gbm_pkg::REG_LIMIT_IDX);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= gbm_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit <= pwdata[gbm_pkg::LIMIT_W-1:0];
    end
  end

  assign prdata = reg_sel ? gbm_pkg::APB_DATA_W'(limit) : '0;

  // Controller.
  gbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_present (in_item.box_present),
    .in_last    (in_item.last_box),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath.
  gbm_dpath #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .limit     (limit),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

// ----- sim/greedy_box_merge_top_tb.sv -----
// Self-checking testbench for the greedy box merge block.
`timescale 1ns / 1ps

module greedy_box_merge_top_tb;

  localparam int MAX_BOXES = gbm_pkg::MAX_BOXES_DEF;
  localparam int COORD_MAX = (1 << gbm_pkg::COORD_W) - 1;
  localparam int SETTLE_CYCLES = 2 * MAX_BOXES + 30;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int PHASE_ITEMS = 35;
  localparam logic [gbm_pkg::APB_ADDR_W-1:0] LIMIT_ADDR = {gbm_pkg::REG_LIMIT_IDX, 2'b00};
  localparam logic [gbm_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

  // Receiver stall patterns.
  typedef enum int {RX_OPEN, RX_BUSY, RX_STRIDE, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  gbm_pkg::in_item_t in_item;
  logic res_valid;
  logic res_ready;
  gbm_pkg::out_item_t res_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [gbm_pkg::APB_ADDR_W-1:0] paddr;
  logic [gbm_pkg::APB_DATA_W-1:0] pwdata;
  logic [gbm_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  // Predictor state: the boxes of the open frame and the merge limit.
  gbm_pkg::box_t stored_boxes[MAX_BOXES];
  int unsigned box_areas[MAX_BOXES];
  bit box_merged[MAX_BOXES];
  int stored_count;
  logic [gbm_pkg::LIMIT_W-1:0] merge_limit;
  gbm_pkg::out_item_t pending_unions[$];

  int err_count;
  int idle_cycles;
  int boxes_sent;
  bit sender_gaps;
  int burst_left;
  bit hold_req;
  int hold_left;
  rx_mode_t rx_mode;
  int rx_mode_left;
  int rx_phase;
  gbm_pkg::out_item_t want_union;

  greedy_box_merge_top #(.MAX_BOXES(MAX_BOXES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item(res_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int span(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Stores one box item and, when it closes the frame, queues the merged unions.
  function automatic void accept_box_item(gbm_pkg::in_item_t it);
    gbm_pkg::box_t u;
    gbm_pkg::box_t b;
    int seed;
    int best;
    int cx;
    int cy;
    int dist_sq;
    bit found;
    int n_unions;
    gbm_pkg::out_item_t res;
    if (it.box_present && stored_count < MAX_BOXES) begin
      b.left = it.left_edge;
      b.top = it.top_edge;
      b.right = it.right_edge;
      b.bottom = it.bottom_edge;
      stored_boxes[stored_count] = b;
      box_areas[stored_count] = span(int'(b.bottom), int'(b.top)) *
                                span(int'(b.right), int'(b.left));
      box_merged[stored_count] = 1'b0;
      stored_count++;
    end
    if (!it.last_box) return;
    n_unions = 0;
    forever begin
      // Largest unmerged area wins, the first one on ties.
      found = 1'b0;
      best = 0;
      seed = 0;
      for (int i = 0; i < stored_count; i++) begin
        if (!box_merged[i] && (!found || box_areas[i] > best)) begin
          best = box_areas[i];
          seed = i;
          found = 1'b1;
        end
      end
      if (!found || best == 0) break;
      u = stored_boxes[seed];
      cx = (int'(u.left) + int'(u.right)) / 2;
      cy = (int'(u.top) + int'(u.bottom)) / 2;
      // Fold in every unmerged box whose center is close to the seed's center.
      for (int i = 0; i < stored_count; i++) begin
        if (!box_merged[i]) begin
          b = stored_boxes[i];
          dist_sq = span(cx, (int'(b.left) + int'(b.right)) / 2) ** 2 +
                    span(cy, (int'(b.top) + int'(b.bottom)) / 2) ** 2;
          if (dist_sq < int'(merge_limit)) begin
            if (b.bottom > u.bottom) u.bottom = b.bottom;
            if (b.left < u.left) u.left = b.left;
            if (b.right > u.right) u.right = b.right;
            if (b.top < u.top) u.top = b.top;
            box_merged[i] = 1'b1;
          end
        end
      end
      box_merged[seed] = 1'b1;
      res.out_left = u.left;
      res.out_top = u.top;
      res.out_right = u.right;
      res.out_bottom = u.bottom;
      res.out_valid = 1'b1;
      res.out_last = 1'b0;
      pending_unions.push_back(res);
      n_unions++;
    end
    // A frame without unions reports one empty result.
    if (n_unions == 0) begin
      res = '0;
      pending_unions.push_back(res);
    end
    res = pending_unions.pop_back();
    res.out_last = 1'b1;
    pending_unions.push_back(res);
    stored_count = 0;
    for (int i = 0; i < MAX_BOXES; i++) box_merged[i] = 1'b0;
  endfunction

  function automatic gbm_pkg::in_item_t box_item(int l, int t, int r, int b, bit last);
    gbm_pkg::in_item_t it;
    it.left_edge = gbm_pkg::COORD_W'(l);
    it.top_edge = gbm_pkg::COORD_W'(t);
    it.right_edge = gbm_pkg::COORD_W'(r);
    it.bottom_edge = gbm_pkg::COORD_W'(b);
    it.box_present = 1'b1;
    it.last_box = last;
    return it;
  endfunction

  function automatic gbm_pkg::in_item_t end_item(bit last);
    gbm_pkg::in_item_t it;
    it = '0;
    it.left_edge = gbm_pkg::COORD_W'($urandom);
    it.bottom_edge = gbm_pkg::COORD_W'($urandom);
    it.last_box = last;
    return it;
  endfunction

  // Random box around a cluster center, sometimes flat, swapped or fully random.
  function automatic gbm_pkg::in_item_t random_box(int cx, int cy, bit last);
    int x;
    int y;
    int hw;
    int hh;
    int l;
    int t;
    int r;
    int b;
    int tmp;
    if ($urandom_range(0, 7) == 0) begin
      l = $urandom_range(0, COORD_MAX);
      t = $urandom_range(0, COORD_MAX);
      r = $urandom_range(0, COORD_MAX);
      b = $urandom_range(0, COORD_MAX);
    end else begin
      x = cx + int'($urandom_range(0, 80)) - 40;
      y = cy + int'($urandom_range(0, 80)) - 40;
      hw = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 60));
      hh = $urandom_range(0, 60);
      l = clamp_coord(x - hw);
      r = clamp_coord(x + hw);
      t = clamp_coord(y - hh);
      b = clamp_coord(y + hh);
      if ($urandom_range(0, 9) == 0) begin
        tmp = l;
        l = r;
        r = tmp;
      end
      if ($urandom_range(0, 9) == 0) begin
        tmp = t;
        t = b;
        b = tmp;
      end
    end
    return box_item(l, t, r, b, last);
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after it is taken.
  task automatic send_item(input gbm_pkg::in_item_t it);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    accept_box_item(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_unions_done();
    while (pending_unions.size() != 0) @(negedge clk);
  endtask

  // Writes the merge limit and reads it back; only called while the block is idle.
  task automatic write_limit(input logic [gbm_pkg::LIMIT_W-1:0] value);
    wait_unions_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = LIMIT_ADDR;
    pwdata = gbm_pkg::APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    merge_limit = value;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== gbm_pkg::APB_DATA_W'(value)) begin
      err_count++;
      $display("%0t: limit read back expected %0d, got %0d", $time, value, prdata);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // One random frame: clustered boxes with some noise, closed by a box or an empty item.
  task automatic send_random_frame(input int n_boxes);
    int cxs[3];
    int cys[3];
    int n_clusters;
    int k;
    bit close_on_box;
    bit flat_frame;
    gbm_pkg::in_item_t it;
    n_clusters = $urandom_range(1, 3);
    for (int c = 0; c < 3; c++) begin
      cxs[c] = $urandom_range(0, COORD_MAX);
      cys[c] = $urandom_range(0, COORD_MAX);
    end
    close_on_box = $urandom_range(0, 1);
    flat_frame = ($urandom_range(0, 11) == 0);
    sender_gaps = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n_boxes; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(end_item(1'b0));
      k = $urandom_range(0, n_clusters - 1);
      it = random_box(cxs[k], cys[k], close_on_box && (i == n_boxes - 1));
      // A frame of flat boxes only gives the empty result.
      if (flat_frame) it.right_edge = it.left_edge;
      send_item(it);
      boxes_sent++;
    end
    if (!close_on_box) begin
      send_item(end_item(1'b1));
      boxes_sent++;
    end
  endtask

  task automatic test_directed_cases();
    write_limit(gbm_pkg::LIMIT_RESET);
    sender_gaps = 1'b1;
    // Full-range box, then an empty frame.
    send_item(box_item(0, 0, COORD_MAX, COORD_MAX, 1'b1));
    send_item(end_item(1'b1));
    // Ignored empty item, then a frame with only a flat box.
    send_item(end_item(1'b0));
    send_item(box_item(500, 500, 500, 600, 1'b1));
    // Swapped edges are kept as given.
    send_item(box_item(COORD_MAX, COORD_MAX, 0, 0, 1'b1));
    // Equal areas, a flat box near the seed and a far box; closed by an empty item.
    send_item(box_item(100, 100, 140, 140, 1'b0));
    send_item(box_item(110, 105, 150, 145, 1'b0));
    send_item(box_item(120, 120, 120, 130, 1'b0));
    send_item(box_item(800, 800, 900, 850, 1'b0));
    send_item(end_item(1'b1));
    // Centers at 71 and 72 pixels from the seed: only the nearer one merges.
    send_item(box_item(200, 300, 260, 340, 1'b0));
    send_item(box_item(282, 300, 322, 340, 1'b0));
    send_item(box_item(281, 301, 321, 341, 1'b1));
    wait_unions_done();
  endtask

  task automatic test_store_overflow();
    sender_gaps = 1'b0;
    // Every box stands alone; boxes past the store are dropped, last still acts.
    write_limit('0);
    for (int i = 0; i < MAX_BOXES + 6; i++)
      send_item(random_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           i == MAX_BOXES + 5));
    // Everything merges into one union.
    write_limit(LIMIT_MAX);
    for (int i = 0; i < MAX_BOXES + 2; i++)
      send_item(random_box(512, 512, 1'b0));
    send_item(end_item(1'b1));
    boxes_sent += 2 * MAX_BOXES + 9;
    wait_unions_done();
  endtask

  task automatic test_output_backpressure();
    write_limit(gbm_pkg::LIMIT_W'(2097152));
    // The receiver holds off while frames keep coming, so the input stalls.
    hold_req = 1'b1;
    sender_gaps = 1'b0;
    for (int f = 0; f < 8; f++) begin
      for (int i = 0; i < 3; i++)
        send_item(random_box(300, 700, i == 2));
      boxes_sent += 3;
    end
    wait_unions_done();
  endtask

  task automatic test_random_frames(input logic [gbm_pkg::LIMIT_W-1:0] limit_value);
    int target;
    write_limit(limit_value);
    target = boxes_sent + PHASE_ITEMS;
    while (boxes_sent < target)
      send_random_frame(($urandom_range(0, 19) == 0) ? $urandom_range(9, 30)
                                                     : $urandom_range(1, 8));
    in_valid = 1'b0;
  endtask

  // Receiver stalls: a long hold on request, otherwise changing patterns.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(64, 256);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN: res_ready = 1'b1;
        RX_BUSY: res_ready = ($urandom_range(0, 9) < 7);
        RX_STRIDE: res_ready = (rx_phase % 4 == 0);
        default: res_ready = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Each accepted result is compared with the oldest expected union.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_unions.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected, expected nothing, got %h", $time, res_item);
      end else begin
        want_union = pending_unions.pop_front();
        check_field("out_left", want_union.out_left, res_item.out_left);
        check_field("out_top", want_union.out_top, res_item.out_top);
        check_field("out_right", want_union.out_right, res_item.out_right);
        check_field("out_bottom", want_union.out_bottom, res_item.out_bottom);
        check_field("out_valid", want_union.out_valid, res_item.out_valid);
        check_field("out_last", want_union.out_last, res_item.out_last);
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (res_valid && res_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("greedy_box_merge_top test failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    res_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    stored_count = 0;
    merge_limit = gbm_pkg::LIMIT_RESET;
    err_count = 0;
    idle_cycles = 0;
    boxes_sent = 0;
    sender_gaps = 1'b1;
    burst_left = 0;
    hold_req = 1'b0;
    hold_left = 0;
    rx_mode = RX_OPEN;
    rx_mode_left = 0;
    rx_phase = 0;
    for (int i = 0; i < MAX_BOXES; i++) box_merged[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_store_overflow();
    test_output_backpressure();
    test_random_frames(gbm_pkg::LIMIT_RESET);
    test_random_frames(gbm_pkg::LIMIT_W'(1));
    test_random_frames(gbm_pkg::LIMIT_W'(2097152));
    test_random_frames(LIMIT_MAX);
    test_random_frames(gbm_pkg::LIMIT_W'($urandom_range(0, 40000)));
    test_random_frames('0);

    // Drain, then give the block time to show any stray result.
    wait_unions_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0)
      $display("greedy_box_merge_top test passed");
    else
      $display("greedy_box_merge_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gbm_pkg.sv
hw/rtl/gbm_ctrl.sv
hw/rtl/gbm_dpath.sv
hw/rtl/greedy_box_merge_top.sv
sim/greedy_box_merge_top_tb.sv
